@@ hw/rtl/hsv_pkg.sv @@
package hsv_pkg;

    localparam int unsigned HueBits    = 16;
    localparam int unsigned ChanBits   = 8;
    localparam int unsigned StepBits   = 11;
    localparam int unsigned HueSteps   = 1530;
    localparam int unsigned RampWidth  = 255;
    localparam int unsigned HueRound   = 32768;
    localparam int unsigned InBits     = HueBits + 2 * ChanBits;
    localparam int unsigned OutBits    = 3 * ChanBits;

    typedef logic [ChanBits-1:0] t_chan;
    typedef logic [StepBits-1:0] t_step;

endpackage

@@ hw/rtl/hsv_to_rgb_pixel.sv @@
// hsv to rgb pixel converter, one pixel per transaction on each side
//
// slave channel s_axis: one pixel as hue (16 bit), saturation and brightness
// master channel m_axis: the matching red, green and blue bytes
//
// the conversion runs through four register stages: hue rescale multiply,
// ramp select, saturation multiply, brightness add and multiply. the last
// stage is the output register. throughput is one pixel every cycle while
// the receiver keeps m_axis_tready high.
//
// each stage holds its item until the next stage is free, so a stalled
// receiver fills the empty stages first and only then drops s_axis_tready;
// nothing is lost or repeated. a held result keeps its data stable.
//
// reset (i_rst_n low at a clock edge) empties all stages; the block then
// accepts pixels on the next cycle.
module hsv_to_rgb_pixel
    import hsv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [InBits-1:0]  s_axis_tdata,   // hue[15:0], saturation[23:16], brightness[31:24]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OutBits-1:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    t_step r_h;
    t_chan r_sat1, r_val1, r_sat2, r_val2, r_sat3, r_val3;
    t_chan r_r, r_g, r_b;
    t_chan r_pr, r_pg, r_pb;
    t_chan r_or, r_og, r_ob;

    logic [HueBits-1:0] in_hue;
    t_chan in_sat, in_val;
    logic [26:0] n_hsum;
    t_step n_h;
    t_chan n_r, n_g, n_b;
    logic [8:0] sat_p1, val_p1;
    logic [16:0] prod_r, prod_g, prod_b;
    logic [8:0] t_r, t_g, t_b;
    logic [17:0] sh_r, sh_g, sh_b;

    assign rdy4 = !r_v4 || m_axis_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {r_ob, r_og, r_or};

    assign in_hue = s_axis_tdata[HueBits-1:0];
    assign in_sat = s_axis_tdata[HueBits+ChanBits-1:HueBits];
    assign in_val = s_axis_tdata[InBits-1:HueBits+ChanBits];

    // hue rescale onto 0..1530 with rounding
    assign n_hsum = 27'(in_hue) * 27'(HueSteps) + 27'(HueRound);
    assign n_h    = n_hsum[26:16];

    // six ramps
    always_comb begin
        n_r = '0;
        n_g = '0;
        n_b = '0;
        if (r_h < StepBits'(2 * RampWidth)) begin
            if (r_h < StepBits'(RampWidth)) begin
                n_r = t_chan'(RampWidth);
                n_g = r_h[ChanBits-1:0];
            end else begin
                n_r = t_chan'(StepBits'(2 * RampWidth) - r_h);
                n_g = t_chan'(RampWidth);
            end
        end else if (r_h < StepBits'(4 * RampWidth)) begin
            if (r_h < StepBits'(3 * RampWidth)) begin
                n_g = t_chan'(RampWidth);
                n_b = t_chan'(r_h - StepBits'(2 * RampWidth));
            end else begin
                n_g = t_chan'(StepBits'(4 * RampWidth) - r_h);
                n_b = t_chan'(RampWidth);
            end
        end else if (r_h < StepBits'(HueSteps)) begin
            if (r_h < StepBits'(5 * RampWidth)) begin
                n_r = t_chan'(r_h - StepBits'(4 * RampWidth));
                n_b = t_chan'(RampWidth);
            end else begin
                n_r = t_chan'(RampWidth);
                n_b = t_chan'(StepBits'(HueSteps) - r_h);
            end
        end else begin
            n_r = t_chan'(RampWidth);
        end
    end

    assign sat_p1 = {1'b0, r_sat2} + 9'd1;
    assign prod_r = {9'd0, r_r} * {8'd0, sat_p1};
    assign prod_g = {9'd0, r_g} * {8'd0, sat_p1};
    assign prod_b = {9'd0, r_b} * {8'd0, sat_p1};

    assign val_p1 = {1'b0, r_val3} + 9'd1;
    assign t_r  = {1'b0, r_pr} + 9'(RampWidth) - {1'b0, r_sat3};
    assign t_g  = {1'b0, r_pg} + 9'(RampWidth) - {1'b0, r_sat3};
    assign t_b  = {1'b0, r_pb} + 9'(RampWidth) - {1'b0, r_sat3};
    assign sh_r = {9'd0, t_r} * {9'd0, val_p1};
    assign sh_g = {9'd0, t_g} * {9'd0, val_p1};
    assign sh_b = {9'd0, t_b} * {9'd0, val_p1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && s_axis_tvalid) begin
            r_h    <= n_h;
            r_sat1 <= in_sat;
            r_val1 <= in_val;
        end
        if (rdy2 && r_v1) begin
            r_r    <= n_r;
            r_g    <= n_g;
            r_b    <= n_b;
            r_sat2 <= r_sat1;
            r_val2 <= r_val1;
        end
        if (rdy3 && r_v2) begin
            r_pr   <= prod_r[15:8];
            r_pg   <= prod_g[15:8];
            r_pb   <= prod_b[15:8];
            r_sat3 <= r_sat2;
            r_val3 <= r_val2;
        end
        if (rdy4 && r_v3) begin
            r_or <= sh_r[15:8];
            r_og <= sh_g[15:8];
            r_ob <= sh_b[15:8];
        end
    end

endmodule

@@ hw/rtl/hsv_chk.sv @@
module hsv_chk
    import hsv_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [InBits-1:0]  s_axis_tdata,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [OutBits-1:0] m_axis_tdata
);

    // held result keeps its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("held result changed");

    // a free receiver never blocks the input
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked with free receiver");

    // accepted pixel reaches the output while the receiver stays ready
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("pixel did not arrive in time");

    // reset empties the pipeline
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind hsv_to_rgb_pixel hsv_chk u_chk (.*);

@@ verif/tb.sv @@
module tb
    import hsv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NumRandom  = 1750;
    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned StallLen   = 300;
    localparam int unsigned StallAt    = 1200;
    localparam int unsigned QuietLo    = 400;
    localparam int unsigned QuietHi    = 700;
    localparam int unsigned TailCycles = 16;

    typedef struct packed {
        t_chan            brightness;
        t_chan            saturation;
        logic [HueBits-1:0] hue;
    } t_pixel;

    typedef struct packed {
        t_chan blue;
        t_chan green;
        t_chan red;
    } t_rgb;

    typedef struct {
        t_pixel px;
        bit     drain_first;
    } t_pending;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [InBits-1:0]  s_axis_tdata = '0;   // hue[15:0], saturation[23:16], brightness[31:24]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OutBits-1:0] m_axis_tdata;        // red[7:0], green[15:8], blue[23:16]

    t_pending    pixel_q[$];
    t_rgb        rgb_q[$];
    int unsigned n_sent = 0;
    int unsigned n_recv = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned stall_left = 0;
    bit          stall_done = 1'b0;

    hsv_to_rgb_pixel dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_chan shade(int unsigned base, int unsigned sat, int unsigned val);
        int unsigned t;
        t = ((base * (sat + 1)) >> 8) + (255 - sat);
        return t_chan'((t * (val + 1)) >> 8);
    endfunction

    function automatic t_rgb hsv_convert(t_pixel px);
        int unsigned h;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        t_rgb        rgb;
        h = (int'(px.hue) * HueSteps + HueRound) >> 16;
        if (h < RampWidth) begin
            r = 255; g = h; b = 0;
        end else if (h < 2 * RampWidth) begin
            r = 2 * RampWidth - h; g = 255; b = 0;
        end else if (h < 3 * RampWidth) begin
            r = 0; g = 255; b = h - 2 * RampWidth;
        end else if (h < 4 * RampWidth) begin
            r = 0; g = 4 * RampWidth - h; b = 255;
        end else if (h < 5 * RampWidth) begin
            r = h - 4 * RampWidth; g = 0; b = 255;
        end else if (h < HueSteps) begin
            r = 255; g = 0; b = HueSteps - h;
        end else begin
            r = 255; g = 0; b = 0;
        end
        rgb.red   = shade(r, px.saturation, px.brightness);
        rgb.green = shade(g, px.saturation, px.brightness);
        rgb.blue  = shade(b, px.saturation, px.brightness);
        return rgb;
    endfunction

    task automatic add_pixel(int unsigned hue, int unsigned sat, int unsigned val, bit drain);
        t_pending item;
        item.px.hue        = hue[HueBits-1:0];
        item.px.saturation = sat[ChanBits-1:0];
        item.px.brightness = val[ChanBits-1:0];
        item.drain_first   = drain;
        pixel_q.push_back(item);
    endtask

    function automatic int unsigned pick_chan();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            return $urandom_range(0, 255);
        end
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return 254;
            default: return 255;
        endcase
    endfunction

    function automatic int unsigned pick_hue();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(65500, 65535);
        end
        return $urandom_range(0, 65535);
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_pending item;
        bit       quiet;
        quiet = (n_sent >= QuietLo) && (n_sent < QuietHi);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pixel_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (pixel_q[0].drain_first && (s_axis_tvalid || n_sent != n_recv)) begin
                s_axis_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 33) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom();
            end else begin
                item = pixel_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= item.px;
            end
        end
    end

    // receiver with one long hold-off
    always @(posedge i_clk) begin
        bit quiet;
        quiet = (n_sent >= QuietLo) && (n_sent < QuietHi);
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!stall_done && n_sent >= StallAt) begin
            m_axis_tready <= 1'b0;
            stall_done <= 1'b1;
            stall_left <= StallLen;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 33);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rgb want;
        t_rgb got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (rgb_q.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %h", $time, got);
                    mismatch_cnt++;
                end else begin
                    want = rgb_q.pop_front();
                    if (got.red !== want.red) begin
                        $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
                        mismatch_cnt++;
                    end
                    if (got.green !== want.green) begin
                        $display("%0t: green expected %0d actual %0d",
                                 $time, want.green, got.green);
                        mismatch_cnt++;
                    end
                    if (got.blue !== want.blue) begin
                        $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
                        mismatch_cnt++;
                    end
                end
                n_recv <= n_recv + 1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                rgb_q.push_back(hsv_convert(s_axis_tdata));
                n_sent <= n_sent + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("%0t: timeout, %0d sent, %0d received", $time, n_sent, n_recv);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        // ramp edges and the top of the hue circle
        add_pixel(0, 255, 255, 1'b0);
        add_pixel(10922, 255, 255, 1'b0);
        add_pixel(10923, 255, 255, 1'b0);
        add_pixel(21845, 255, 255, 1'b0);
        add_pixel(21846, 255, 255, 1'b0);
        add_pixel(32768, 255, 255, 1'b0);
        add_pixel(43690, 255, 255, 1'b0);
        add_pixel(43691, 255, 255, 1'b0);
        add_pixel(54613, 255, 255, 1'b0);
        add_pixel(54614, 255, 255, 1'b0);
        add_pixel(65513, 255, 255, 1'b0);
        add_pixel(65514, 255, 255, 1'b0);
        add_pixel(65535, 255, 255, 1'b0);
        // grey, black and small values
        add_pixel(12345, 0, 255, 1'b0);
        add_pixel(40000, 0, 128, 1'b0);
        add_pixel(5000, 255, 0, 1'b0);
        add_pixel(65535, 0, 0, 1'b0);
        add_pixel(30000, 1, 1, 1'b0);
        add_pixel(60000, 254, 254, 1'b0);
        add_pixel(20000, 128, 64, 1'b0);
        for (int i = 0; i < NumRandom; i++) begin
            add_pixel(pick_hue(), pick_chan(), pick_chan(), i == 0 || i == 800);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // checked between edges so that every update of the edge has settled
        while (pixel_q.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        while (n_recv != n_sent) @(negedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        $display("tb: %0d pixels converted: ramp edges, hue wrap, grey and black cases,",
                 n_recv);
        $display("tb: random pixels under random back-pressure and a %0d-cycle output hold",
                 StallLen);
        if (mismatch_cnt == 0 && rgb_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
